// File: sv/mma_pkg.sv
// Shared constants, types and register codes for the multichannel moving average.
// Used by the top level, the divide-by-window unit and the port checker.
`default_nettype none

package mma_pkg;

	localparam int WINDOW     = 40;
	localparam int CHANNELS   = 3;
	localparam int ADC_BITS   = 12;
	localparam int CH_W       = 2;
	localparam int SAMPLE_W   = 24;
	localparam int SUM_W      = 30;
	localparam int POS_W      = 6;
	localparam int DATA_IN_W  = 16;
	localparam int REG_IDX_W  = 3;
	localparam int RING_DEPTH = CHANNELS * WINDOW;
	localparam int ADDR_W     = $clog2(RING_DEPTH);

	// Gain times count, and the Q8 value before saturation.
	localparam int PROD_W = SAMPLE_W + ADC_BITS + 1;
	localparam int RND_W  = PROD_W - 8;
	localparam int MAP_W  = RND_W + 1;

	localparam logic signed [MAP_W-1:0] SAT_HI = MAP_W'((2 ** (SAMPLE_W - 1)) - 1);
	localparam logic signed [MAP_W-1:0] SAT_LO = -SAT_HI - MAP_W'(1);

	localparam logic signed [SAMPLE_W-1:0] GAIN_RESET = SAMPLE_W'(65536);

	// The window splits into a power of two and an odd factor.
	// The odd factor is divided by a reciprocal multiply that is exact for
	// every magnitude the running sum can reach.
	localparam int PRE_SHIFT = 3;
	localparam int DIV_ODD   = WINDOW >> PRE_SHIFT;
	localparam int MAG_W     = SUM_W - PRE_SHIFT;
	localparam int DIV_SHIFT = 29;
	localparam int RECIP_W   = 27;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD));
	localparam int DPROD_W   = MAG_W + RECIP_W;

	typedef logic [CH_W-1:0]            ch_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_CH0   = 3'd0,
		REG_OFFSET_CH0 = 3'd1,
		REG_GAIN_CH1   = 3'd2,
		REG_OFFSET_CH1 = 3'd3,
		REG_GAIN_CH2   = 3'd4,
		REG_OFFSET_CH2 = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		ch_t  ch;
		sum_t sum;
	} div_req_t;

endpackage

`default_nettype wire

// File: sv/mma_div.sv
// Pipelined divide of a channel's running sum by the window length, toward zero.
// Three elastic stages with valid/ready; depends on mma_pkg.
`default_nettype none

module mma_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mma_pkg::div_req_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mma_pkg::ch_t      out_channel,
	output mma_pkg::sample_t  out_average
);
	import mma_pkg::*;

	logic               v_s1, v_s2, v_s3;
	logic               neg_s1, neg_s2;
	ch_t                ch_s1, ch_s2, ch_s3;
	logic [MAG_W-1:0]   mag_s1;
	logic [DPROD_W-1:0] prod_s2;
	sample_t            avg_s3;
	logic               rdy1, rdy2, rdy3;
	logic [SUM_W-1:0]   abs_val;
	logic [SAMPLE_W-1:0] quot;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign abs_val = in_data.sum[SUM_W-1] ? SUM_W'(-in_data.sum) : SUM_W'(in_data.sum);
	assign quot    = prod_s2[DIV_SHIFT +: SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			ch_s1  <= in_data.ch;
			neg_s1 <= in_data.sum[SUM_W-1];
			mag_s1 <= abs_val[SUM_W-1:PRE_SHIFT];
		end
		if (rdy2 && v_s1) begin
			ch_s2   <= ch_s1;
			neg_s2  <= neg_s1;
			prod_s2 <= DPROD_W'(mag_s1) * DPROD_W'(RECIP);
		end
		if (rdy3 && v_s2) begin
			ch_s3  <= ch_s2;
			avg_s3 <= neg_s2 ? sample_t'(-quot) : sample_t'(quot);
		end
	end

	assign out_valid   = v_s3;
	assign out_channel = ch_s3;
	assign out_average = avg_s3;

endmodule

`default_nettype wire

// File: sv/multichannel_moving_average.sv
// Top level of the multichannel moving average: scaling, ring memory and sums.
// Depends on mma_pkg and mma_div.
//
// Each input transfer carries a channel in s_axis_tuser and a raw count in
// s_axis_tdata. The count is scaled by the channel's gain and offset,
// saturated to 24 bits, stored in the channel's 40-entry ring, and the
// channel's running sum is updated. Each output transfer carries the channel
// in m_axis_tuser and the window average in m_axis_tdata. A channel of 3 is
// accepted and dropped without a result.
// One item is accepted per cycle. Each item goes through ring read and
// multiply, scaling and saturation, and the stages of the reciprocal divide;
// the sum update and ring write-back happen as it enters the divide. Every
// stage is elastic, so the block keeps accepting items while a result waits,
// until the pipeline is full; a stalled receiver then holds the input side.
// Reset clears the sums, the write positions and the ring's per-entry valid
// bits, so no clearing pass is needed; gains return to 1.0 and offsets to 0.
// Configuration writes are taken in any cycle and must be made while idle.
`default_nettype none

module multichannel_moving_average (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [mma_pkg::DATA_IN_W-1:0]     s_axis_tdata,  // adc_sample[11:0], zero fill
	input  logic [mma_pkg::CH_W-1:0]          s_axis_tuser,  // channel[1:0]
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [mma_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // average[23:0]
	output logic [mma_pkg::CH_W-1:0]          m_axis_tuser,  // out_channel[1:0]
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mma_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [mma_pkg::SAMPLE_W-1:0]      cfg_data
);
	import mma_pkg::*;

	sample_t gain_q [CHANNELS];
	sample_t offset_q [CHANNELS];
	logic [POS_W-1:0] wpos_q [CHANNELS];
	sum_t    sum_q [CHANNELS];

	logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] ring_vld_q;

	ch_t                 in_ch, sel_ch;
	logic [ADC_BITS-1:0] in_cnt;
	logic                in_ok, accept, load;
	logic [POS_W-1:0]    slot, slot_nxt;
	logic [ADDR_W-1:0]   ring_addr;
	logic signed [PROD_W-1:0] prod;

	logic                v_s1, rdv_s1;
	ch_t                 ch_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [SAMPLE_W-1:0] rd_s1;

	logic signed [PROD_W-1:0] rnd_full;
	logic signed [RND_W-1:0]  rnd;
	logic signed [MAP_W-1:0]  map_wide;
	sample_t                  map_sat;

	logic                v_s2;
	ch_t                 ch_s2;
	logic [ADDR_W-1:0]   addr_s2;
	sample_t             m_s2, old_s2;
	sum_t                sum_new;

	logic                rdy1, rdy2, fire2, div_ready;
	div_req_t            div_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				gain_q[i]   <= GAIN_RESET;
				offset_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_CH0:   gain_q[0]   <= cfg_data;
				REG_OFFSET_CH0: offset_q[0] <= cfg_data;
				REG_GAIN_CH1:   gain_q[1]   <= cfg_data;
				REG_OFFSET_CH1: offset_q[1] <= cfg_data;
				REG_GAIN_CH2:   gain_q[2]   <= cfg_data;
				REG_OFFSET_CH2: offset_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ch     = s_axis_tuser;
	assign in_cnt    = s_axis_tdata[ADC_BITS-1:0];
	assign in_ok     = in_ch < CH_W'(CHANNELS);
	assign sel_ch    = in_ok ? in_ch : '0;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign load      = accept && in_ok;
	assign slot      = wpos_q[sel_ch];
	assign slot_nxt  = (slot == POS_W'(WINDOW - 1)) ? '0 : slot + POS_W'(1);
	assign ring_addr = ADDR_W'(sel_ch) * ADDR_W'(WINDOW) + ADDR_W'(slot);
	assign prod      = gain_q[sel_ch] * signed'({1'b0, in_cnt});

	assign rdy2          = !v_s2 || div_ready;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;
	assign fire2         = v_s2 && div_ready;

	// Scaling to Q8 with round half up, then offset and saturation.
	assign rnd_full = prod_s1 + PROD_W'(128);
	assign rnd      = rnd_full[PROD_W-1:8];
	assign map_wide = MAP_W'(rnd) + MAP_W'(offset_q[ch_s1]);
	assign map_sat  = (map_wide > SAT_HI) ? sample_t'(SAT_HI) :
		(map_wide < SAT_LO) ? sample_t'(SAT_LO) : sample_t'(map_wide);

	assign sum_new = sum_q[ch_s2] - SUM_W'(old_s2) + SUM_W'(m_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			rdv_s1     <= 1'b0;
			ring_vld_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				wpos_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else begin
			if (rdy1) v_s1 <= load;
			if (rdy2) v_s2 <= v_s1;
			if (load) begin
				wpos_q[in_ch] <= slot_nxt;
				rdv_s1        <= ring_vld_q[ring_addr];
			end
			if (fire2) begin
				ring_vld_q[addr_s2] <= 1'b1;
				sum_q[ch_s2]        <= sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rd_s1 <= ring_mem[ring_addr];
		end
		if (fire2) begin
			ring_mem[addr_s2] <= m_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch_s1   <= in_ch;
			addr_s1 <= ring_addr;
			prod_s1 <= prod;
		end
		if (rdy2 && v_s1) begin
			ch_s2   <= ch_s1;
			addr_s2 <= addr_s1;
			m_s2    <= map_sat;
			old_s2  <= rdv_s1 ? sample_t'(rd_s1) : '0;
		end
	end

	assign div_req.ch  = ch_s2;
	assign div_req.sum = sum_new;

	mma_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s2),
		.in_ready    (div_ready),
		.in_data     (div_req),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_channel (m_axis_tuser),
		.out_average (m_axis_tdata)
	);

endmodule

`default_nettype wire

// File: sv/mma_checker.sv
// Port-level checks for the multichannel moving average, bound to the top level.
// Depends on mma_pkg.
`default_nettype none

module mma_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [mma_pkg::SAMPLE_W-1:0]  m_axis_tdata,
	input logic [mma_pkg::CH_W-1:0]      m_axis_tuser
);
	import mma_pkg::*;

	// A result never leaves unless its transfer completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transfer withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output payload changed");

	// Items on an unused channel are dropped, so no result names one.
	a_out_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser < CH_W'(CHANNELS))
		else $error("result on an unused channel");

	// The pipeline is empty right after reset.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_axis_tvalid)
		else $error("result present right after reset");

	// With the output side free and a stage empty, the input side is never held off.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(m_axis_tvalid) && !$past(s_axis_tvalid) && $past(arst_n) |-> s_axis_tready)
		else $error("input held off while the pipeline drains freely");

endmodule

bind multichannel_moving_average mma_checker u_mma_checker (.*);

`default_nettype wire
